FILE: hdl/qap_pkg.sv
// Package for the quantised average pool with requantisation.
// Types, constants and widths for the front, back, requant and top; no dependencies.
`default_nettype none
package qap_pkg;

    localparam int LANES        = 8;
    localparam int BYTE_W       = 8;
    localparam int LANES_W      = LANES * BYTE_W;
    localparam int ACC_W        = 32;
    localparam int TAP_W        = 9;
    localparam int GRP_W        = 8;
    localparam int CHAN_W       = 11;
    localparam int CFG_IDX_W    = 4;
    localparam int CFG_DATA_W   = 32;
    localparam int VLANE_W      = 4;
    localparam int MAX_CHANNELS = 1024;
    localparam int MAX_TAPS     = 256;
    localparam int CMD_DEPTH    = 4;
    localparam int RES_DEPTH    = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BIAS        = 4'd0,
        REG_MULTIPLIER  = 4'd1,
        REG_RIGHT_SHIFT = 4'd2,
        REG_ZERO_POINT  = 4'd3,
        REG_OUT_MIN     = 4'd4,
        REG_OUT_MAX     = 4'd5,
        REG_KERNEL_SIZE = 4'd6,
        REG_CHAN_COUNT  = 4'd7
    } t_reg_idx;

    typedef struct packed {
        logic [31:0]       bias;
        logic [31:0]       multiplier;
        logic [5:0]        right_shift;
        logic [15:0]       zero_point;
        logic [7:0]        out_min;
        logic [7:0]        out_max;
        logic [TAP_W-1:0]  kernel_size;
        logic [CHAN_W-1:0] channel_count;
    } t_cfg;

    // one classified item handed from front to back
    typedef struct packed {
        logic [LANES_W-1:0] lanes;
        logic               first;
        logic               last;
        logic [GRP_W-1:0]   grp;
        logic [VLANE_W-1:0] valid_lanes;
        logic               pixel_end;
    } t_item;

    typedef struct packed {
        logic [LANES_W-1:0] bytes;
        logic [VLANE_W-1:0] valid_lanes;
        logic               pixel_end;
    } t_res;

endpackage
`default_nettype wire

FILE: hdl/qap_ram.sv
// Generic single write, single read RAM with registered read data.
// No dependencies.
`default_nettype none
module qap_ram #(
    parameter int WIDTH = 256,
    parameter int DEPTH = 128,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

FILE: hdl/qap_fifo.sv
// Small synchronous queue built from registers, one read at the head.
// No dependencies.
`default_nettype none
module qap_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    input  wire logic             i_pop,
    output logic      [WIDTH-1:0] o_data,
    output logic                  o_empty,
    output logic                  o_full
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_buf [DEPTH];
    logic [PW-1:0]    r_wp, r_rp;
    logic [CW-1:0]    r_cnt;
    logic             do_push, do_pop;

    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == CW'(DEPTH));
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_buf[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_buf[r_wp] <= i_data;
        end
    end
endmodule
`default_nettype wire

FILE: hdl/qap_front.sv
// Front end: tracks tap and channel group of each accepted item and classifies it.
// Depends on qap_pkg.
`default_nettype none
module qap_front #(
    parameter int MAX_CHANNELS = qap_pkg::MAX_CHANNELS,
    parameter int MAX_TAPS     = qap_pkg::MAX_TAPS
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_accept,
    input  wire logic [qap_pkg::LANES_W-1:0]     i_lanes,
    input  wire qap_pkg::t_cfg                   i_cfg,
    input  wire logic                            i_geom_clear,
    output qap_pkg::t_item                       o_item
);
    logic [qap_pkg::TAP_W-1:0] r_tap, n_tap;
    logic [qap_pkg::GRP_W-1:0] r_grp, n_grp;
    logic [9:0]                taps;
    logic [11:0]               chans;
    logic [8:0]                groups;
    logic [11:0]               base, remain;
    logic                      last_tap, last_grp;

    always_comb begin
        if (i_cfg.kernel_size == '0) begin
            taps = 10'd1;
        end else if (32'(i_cfg.kernel_size) > MAX_TAPS) begin
            taps = 10'(MAX_TAPS);
        end else begin
            taps = {1'b0, i_cfg.kernel_size};
        end
        if (i_cfg.channel_count == '0) begin
            chans = 12'd1;
        end else if (32'(i_cfg.channel_count) > MAX_CHANNELS) begin
            chans = 12'(MAX_CHANNELS);
        end else begin
            chans = {1'b0, i_cfg.channel_count};
        end
        groups   = 9'((chans + 12'd7) >> 3);
        last_tap = ({1'b0, r_tap} + 10'd1) == taps;
        last_grp = ({1'b0, r_grp} + 9'd1) == groups;
        base     = {1'b0, r_grp, 3'b000};
        remain   = chans - base;

        o_item.lanes       = i_lanes;
        o_item.first       = (r_tap == '0);
        o_item.last        = last_tap;
        o_item.grp         = r_grp;
        o_item.valid_lanes = (remain > 12'd8) ? 4'd8 : remain[3:0];
        o_item.pixel_end   = last_grp;

        n_tap = r_tap;
        n_grp = r_grp;
        if (i_accept) begin
            if (last_grp) begin
                n_grp = '0;
                n_tap = last_tap ? '0 : r_tap + 1'b1;
            end else begin
                n_grp = r_grp + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_geom_clear) begin
            r_tap <= '0;
            r_grp <= '0;
        end else begin
            r_tap <= n_tap;
            r_grp <= n_grp;
        end
    end
endmodule
`default_nettype wire

FILE: hdl/qap_requant.sv
// One lane of requantisation: multiply, rounding shift, saturation, offset and clamp.
// Two register stages; depends on qap_pkg.
`default_nettype none
module qap_requant (
    input  wire logic                      i_clk,
    input  wire logic [qap_pkg::ACC_W-1:0] i_acc,
    input  wire qap_pkg::t_cfg             i_cfg,
    output logic      [7:0]                o_byte
);
    logic signed [63:0] r_prod;
    logic               r_neg;
    logic signed [15:0] r_v16;
    logic signed [63:0] p, t;
    logic        [31:0] r32;
    logic signed [16:0] sum;
    logic signed [15:0] v;
    logic        [7:0]  b;

    always_ff @(posedge i_clk) begin
        r_prod <= $signed(i_acc) * $signed(i_cfg.multiplier);
        r_neg  <= i_acc[31];
    end

    always_comb begin
        p = r_prod - 64'(r_neg);
        t = p >>> (i_cfg.right_shift - 6'd1);
        // round half away from zero: floor shift of p (a negative less one) plus the last bit shifted out
        if (i_cfg.right_shift == '0) begin
            r32 = p[31:0];
        end else begin
            r32 = t[32:1] + 32'(t[0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if ($signed(r32) > 32'sd32767) begin
            r_v16 <= 16'sh7fff;
        end else if ($signed(r32) < -32'sd32768) begin
            r_v16 <= 16'sh8000;
        end else begin
            r_v16 <= r32[15:0];
        end
    end

    always_comb begin
        sum = {r_v16[15], r_v16} + {i_cfg.zero_point[15], i_cfg.zero_point};
        if (sum > 17'sd32767) begin
            v = 16'sh7fff;
        end else if (sum < -17'sd32768) begin
            v = 16'sh8000;
        end else begin
            v = sum[15:0];
        end
        if (v < 0) begin
            b = 8'd0;
        end else if (v > 16'sd255) begin
            b = 8'd255;
        end else begin
            b = v[7:0];
        end
        if (b < i_cfg.out_min) begin
            b = i_cfg.out_min;
        end
        if (b > i_cfg.out_max) begin
            b = i_cfg.out_max;
        end
        o_byte = b;
    end
endmodule
`default_nettype wire

FILE: hdl/qap_back.sv
// Back end: accumulator read-modify-write, requantisation lanes and result queue.
// Depends on qap_pkg, qap_ram, qap_fifo and qap_requant.
`default_nettype none
module qap_back #(
    parameter int MAX_CHANNELS = qap_pkg::MAX_CHANNELS
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire qap_pkg::t_item i_item,
    input  wire logic           i_item_empty,
    output logic                o_item_pop,
    input  wire qap_pkg::t_cfg  i_cfg,
    input  wire logic           i_res_pop,
    output qap_pkg::t_res       o_res,
    output logic                o_res_empty
);
    localparam int DEPTH = (MAX_CHANNELS + qap_pkg::LANES - 1) / qap_pkg::LANES;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int ROW_W = qap_pkg::LANES * qap_pkg::ACC_W;
    localparam int CRD_W = $clog2(qap_pkg::RES_DEPTH + 1);

    logic [CRD_W-1:0]    r_crd;
    logic                issue, res_full, res_push, res_pop;

    // stage B: accumulator update
    logic                r_b_vld;
    qap_pkg::t_item      r_b;
    logic                r_byp;
    logic [ROW_W-1:0]    r_byp_data;
    logic [ROW_W-1:0]    rdata, old_row, new_row;
    logic                b_wr;

    // requant stages
    logic                r_c_vld, r_d_vld, r_e_vld;
    logic [ROW_W-1:0]    r_c_acc;
    logic [3:0]          r_c_vl, r_d_vl, r_e_vl;
    logic                r_c_pe, r_d_pe, r_e_pe;
    logic [qap_pkg::LANES_W-1:0] bytes;
    qap_pkg::t_res       res_in;

    assign res_pop    = i_res_pop && !o_res_empty;
    // a result needs a reserved slot in the result queue before it may enter
    assign issue      = !i_item_empty &&
                        (!i_item.last || r_crd < CRD_W'(qap_pkg::RES_DEPTH));
    assign o_item_pop = issue;
    assign b_wr       = r_b_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crd <= '0;
        end else if ((issue && i_item.last) && !res_pop) begin
            r_crd <= r_crd + 1'b1;
        end else if (!(issue && i_item.last) && res_pop) begin
            r_crd <= r_crd - 1'b1;
        end
    end

    qap_ram #(.WIDTH(ROW_W), .DEPTH(DEPTH), .AW(AW)) u_acc (
        .i_clk   (i_clk),
        .i_we    (b_wr),
        .i_waddr (AW'(r_b.grp)),
        .i_wdata (new_row),
        .i_raddr (AW'(i_item.grp)),
        .o_rdata (rdata)
    );

    always_comb begin
        old_row = r_byp ? r_byp_data : rdata;
        for (int l = 0; l < qap_pkg::LANES; l++) begin
            new_row[l*32 +: 32] = (r_b.first ? i_cfg.bias : old_row[l*32 +: 32])
                                  + 32'(r_b.lanes[l*8 +: 8]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
            r_byp   <= 1'b0;
            r_c_vld <= 1'b0;
            r_d_vld <= 1'b0;
            r_e_vld <= 1'b0;
        end else begin
            r_b_vld <= issue;
            // the row being written now is read stale by the item issued now
            r_byp   <= issue && b_wr && (AW'(r_b.grp) == AW'(i_item.grp));
            r_c_vld <= r_b_vld && r_b.last;
            r_d_vld <= r_c_vld;
            r_e_vld <= r_d_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_b        <= i_item;
        r_byp_data <= new_row;
        r_c_acc    <= new_row;
        r_c_vl     <= r_b.valid_lanes;
        r_c_pe     <= r_b.pixel_end;
        r_d_vl     <= r_c_vl;
        r_d_pe     <= r_c_pe;
        r_e_vl     <= r_d_vl;
        r_e_pe     <= r_d_pe;
    end

    for (genvar g = 0; g < qap_pkg::LANES; g++) begin : g_lane
        logic [7:0] lb;
        qap_requant u_rq (
            .i_clk  (i_clk),
            .i_acc  (r_c_acc[g*32 +: 32]),
            .i_cfg  (i_cfg),
            .o_byte (lb)
        );
        assign bytes[g*8 +: 8] = (4'(g) < r_e_vl) ? lb : 8'd0;
    end

    assign res_in.bytes       = bytes;
    assign res_in.valid_lanes = r_e_vl;
    assign res_in.pixel_end   = r_e_pe;
    // credit keeps the queue from filling, so full never blocks here
    assign res_push           = r_e_vld && !res_full;

    qap_fifo #(.WIDTH($bits(qap_pkg::t_res)), .DEPTH(qap_pkg::RES_DEPTH)) u_res (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_in),
        .i_pop   (i_res_pop),
        .o_data  (o_res),
        .o_empty (o_res_empty),
        .o_full  (res_full)
    );
endmodule
`default_nettype wire

FILE: hdl/quantized_average_pool_requant.sv
// Top level of the quantised average pool with requantisation.
// Depends on qap_pkg, qap_fifo, qap_front and qap_back.
//
//  channel   handshake              payload
//  input     push / full            i_lane0..i_lane7
//  result    pop / empty            o_out0..o_out7, o_valid_lanes, o_pixel_end
//  config    i_cfg_valid/o_cfg_ready i_cfg_index, i_cfg_data
//
// One item a cycle while full is low; a result enters the result queue once its
// last-tap item has passed the accumulator RAM read and the two requant stages.
// Synchronous active-low reset clears counters and queues; accumulators hold
// garbage until the first tap of each group writes them. A full result queue
// holds items in the command queue, which then raises full.
`default_nettype none
module quantized_average_pool_requant #(
    parameter int MAX_CHANNELS = qap_pkg::MAX_CHANNELS,
    parameter int MAX_TAPS     = qap_pkg::MAX_TAPS
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              push,
    output logic                                   full,
    input  wire logic [7:0]                        i_lane0,
    input  wire logic [7:0]                        i_lane1,
    input  wire logic [7:0]                        i_lane2,
    input  wire logic [7:0]                        i_lane3,
    input  wire logic [7:0]                        i_lane4,
    input  wire logic [7:0]                        i_lane5,
    input  wire logic [7:0]                        i_lane6,
    input  wire logic [7:0]                        i_lane7,
    output logic                                   empty,
    input  wire logic                              pop,
    output logic      [7:0]                        o_out0,
    output logic      [7:0]                        o_out1,
    output logic      [7:0]                        o_out2,
    output logic      [7:0]                        o_out3,
    output logic      [7:0]                        o_out4,
    output logic      [7:0]                        o_out5,
    output logic      [7:0]                        o_out6,
    output logic      [7:0]                        o_out7,
    output logic      [3:0]                        o_valid_lanes,
    output logic                                   o_pixel_end,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [qap_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [qap_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    qap_pkg::t_cfg  r_cfg;
    qap_pkg::t_item item_in, item_out;
    qap_pkg::t_res  res;
    logic           accept, cfg_wr, geom_clear, cmd_empty, cmd_pop;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid;
    assign accept      = push && !full;
    assign geom_clear  = cfg_wr && (i_cfg_index == qap_pkg::REG_KERNEL_SIZE ||
                                    i_cfg_index == qap_pkg::REG_CHAN_COUNT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.bias          <= '0;
            r_cfg.multiplier    <= '0;
            r_cfg.right_shift   <= '0;
            r_cfg.zero_point    <= '0;
            r_cfg.out_min       <= '0;
            r_cfg.out_max       <= 8'd255;
            r_cfg.kernel_size   <= 9'd1;
            r_cfg.channel_count <= 11'd8;
        end else if (cfg_wr) begin
            unique case (i_cfg_index)
                qap_pkg::REG_BIAS:        r_cfg.bias          <= i_cfg_data;
                qap_pkg::REG_MULTIPLIER:  r_cfg.multiplier    <= i_cfg_data;
                qap_pkg::REG_RIGHT_SHIFT: r_cfg.right_shift   <= i_cfg_data[5:0];
                qap_pkg::REG_ZERO_POINT:  r_cfg.zero_point    <= i_cfg_data[15:0];
                qap_pkg::REG_OUT_MIN:     r_cfg.out_min       <= i_cfg_data[7:0];
                qap_pkg::REG_OUT_MAX:     r_cfg.out_max       <= i_cfg_data[7:0];
                qap_pkg::REG_KERNEL_SIZE: r_cfg.kernel_size   <= i_cfg_data[8:0];
                qap_pkg::REG_CHAN_COUNT:  r_cfg.channel_count <= i_cfg_data[10:0];
                default: ;
            endcase
        end
    end

    qap_front #(.MAX_CHANNELS(MAX_CHANNELS), .MAX_TAPS(MAX_TAPS)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_lanes      ({i_lane7, i_lane6, i_lane5, i_lane4,
                        i_lane3, i_lane2, i_lane1, i_lane0}),
        .i_cfg        (r_cfg),
        .i_geom_clear (geom_clear),
        .o_item       (item_in)
    );

    qap_fifo #(.WIDTH($bits(qap_pkg::t_item)), .DEPTH(qap_pkg::CMD_DEPTH)) u_cmd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (item_in),
        .i_pop   (cmd_pop),
        .o_data  (item_out),
        .o_empty (cmd_empty),
        .o_full  (full)
    );

    qap_back #(.MAX_CHANNELS(MAX_CHANNELS)) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (item_out),
        .i_item_empty (cmd_empty),
        .o_item_pop   (cmd_pop),
        .i_cfg        (r_cfg),
        .i_res_pop    (pop),
        .o_res        (res),
        .o_res_empty  (empty)
    );

    assign o_out0        = res.bytes[7:0];
    assign o_out1        = res.bytes[15:8];
    assign o_out2        = res.bytes[23:16];
    assign o_out3        = res.bytes[31:24];
    assign o_out4        = res.bytes[39:32];
    assign o_out5        = res.bytes[47:40];
    assign o_out6        = res.bytes[55:48];
    assign o_out7        = res.bytes[63:56];
    assign o_valid_lanes = res.valid_lanes;
    assign o_pixel_end   = res.pixel_end;
endmodule
`default_nettype wire

FILE: hdl/qap_check.sv
// Port-level checks for the quantised average pool, bound to the top level.
// No dependencies beyond the top level's ports.
`default_nettype none
module qap_check (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       full,
    input wire logic       empty,
    input wire logic       pop,
    input wire logic [7:0] o_out0,
    input wire logic [7:0] o_out7,
    input wire logic [3:0] o_valid_lanes
);
    a_reset_clean: assert property (@(posedge i_clk)
        !i_rst_n |=> empty && !full) else $error("queues not empty after reset");

    a_vlanes_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> o_valid_lanes != 4'd0 && o_valid_lanes <= 4'd8)
        else $error("valid lane count out of range");

    a_tail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_valid_lanes < 4'd8 |-> o_out7 == 8'd0)
        else $error("lane past the channel count not zero");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_out0) && $stable(o_valid_lanes))
        else $error("waiting result changed");
endmodule

bind quantized_average_pool_requant qap_check u_qap_check (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .full          (full),
    .empty         (empty),
    .pop           (pop),
    .o_out0        (o_out0),
    .o_out7        (o_out7),
    .o_valid_lanes (o_valid_lanes)
);
`default_nettype wire
